/* sv/yuyv_to_rgb24_mirror_unit_assert.svh */
// assertion macros for the yuyv to rgb24 mirror unit
// both use the clk and rst of the module that includes this file
`ifndef YUYV_TO_RGB24_MIRROR_UNIT_ASSERT_SVH
`define YUYV_TO_RGB24_MIRROR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define Y2RGB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("y2rgb assertion failed");
`define Y2RGB_ASSERT_NEXT(label, trig, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (conseq)) \
    else $error("y2rgb assertion failed");
`else
`define Y2RGB_ASSERT(label, prop)
`define Y2RGB_ASSERT_NEXT(label, trig, conseq)
`endif
`endif

/* sv/y2rgb_pkg.sv */
`default_nettype none
package y2rgb_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int LINE_PAIRS_W = 11;
  localparam int FRAME_LINES_W = 12;
  localparam int PAIR_W = 10;
  localparam int LINE_W = 11;
  localparam int PROD_W = 17;
  localparam int TERM_W = 9;
  localparam int SUM_W = 11;

  localparam int MAX_LINE_PAIRS = 1024;
  localparam int MAX_LINES = 2048;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_PAIRS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LINES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIRROR = 2'd2;

  localparam logic [LINE_PAIRS_W-1:0] LINE_PAIRS_RESET = 11'd320;
  localparam logic [FRAME_LINES_W-1:0] FRAME_LINES_RESET = 12'd480;

  localparam logic signed [TERM_W-1:0] CHROMA_OFFSET = 9'sd128;
  localparam logic signed [PROD_W-1:0] COEF_CB = 17'sd454;
  localparam logic signed [PROD_W-1:0] COEF_CR = 17'sd359;
  localparam logic signed [PROD_W-1:0] COEF_GU = 17'sd88;
  localparam logic signed [PROD_W-1:0] COEF_GV = 17'sd183;

  typedef struct packed {
    logic signed [PROD_W-1:0] blue;
    logic signed [PROD_W-1:0] red;
    logic signed [PROD_W-1:0] green;
  } prod_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] cb;
    logic signed [TERM_W-1:0] cr;
    logic signed [TERM_W-1:0] cg;
  } term_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  typedef struct packed {
    logic [PAIR_W-1:0] col;
    logic [LINE_W-1:0] line;
    logic              eol;
    logic              eof;
    logic              mirror;
  } meta_t;

endpackage
`default_nettype wire

/* sv/y2rgb_if.sv */
`default_nettype none
interface y2rgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] y_first;
  logic [7:0] u_chroma;
  logic [7:0] y_second;
  logic [7:0] v_chroma;

  modport source(output valid, y_first, u_chroma, y_second, v_chroma, input ready);
  modport sink(input valid, y_first, u_chroma, y_second, v_chroma, output ready);
endinterface

interface y2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     blue_left;
  logic [7:0]                     green_left;
  logic [7:0]                     red_left;
  logic [7:0]                     blue_right;
  logic [7:0]                     green_right;
  logic [7:0]                     red_right;
  logic [y2rgb_pkg::PAIR_W-1:0]   pair_column;
  logic [y2rgb_pkg::LINE_W-1:0]   line_index;
  logic                           end_of_line;
  logic                           end_of_frame;

  modport source(
    output valid, blue_left, green_left, red_left, blue_right, green_right, red_right,
    output pair_column, line_index, end_of_line, end_of_frame,
    input ready
  );
  modport sink(
    input valid, blue_left, green_left, red_left, blue_right, green_right, red_right,
    input pair_column, line_index, end_of_line, end_of_frame,
    output ready
  );
endinterface
`default_nettype wire

/* sv/y2rgb_chroma.sv */
`default_nettype none
module y2rgb_chroma (
  input  wire logic [7:0]       u_chroma,
  input  wire logic [7:0]       v_chroma,
  output y2rgb_pkg::prod_t      prod
);

  logic signed [y2rgb_pkg::TERM_W-1:0] u_off;
  logic signed [y2rgb_pkg::TERM_W-1:0] v_off;

  always_comb begin
    u_off = $signed({1'b0, u_chroma}) - y2rgb_pkg::CHROMA_OFFSET;
    v_off = $signed({1'b0, v_chroma}) - y2rgb_pkg::CHROMA_OFFSET;
    prod.blue = u_off * y2rgb_pkg::COEF_CB;
    prod.red = v_off * y2rgb_pkg::COEF_CR;
    prod.green = (u_off * y2rgb_pkg::COEF_GU) + (v_off * y2rgb_pkg::COEF_GV);
  end

endmodule
`default_nettype wire

/* sv/y2rgb_lane.sv */
`default_nettype none
module y2rgb_lane (
  input  wire logic [7:0]       luma,
  input  wire y2rgb_pkg::term_t term,
  output y2rgb_pkg::pixel_t     pix
);

  function automatic logic [7:0] sat8(input logic signed [y2rgb_pkg::SUM_W-1:0] x);
    logic [7:0] res;
    priority if (x < 0) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  logic signed [y2rgb_pkg::SUM_W-1:0] luma_s;
  logic signed [y2rgb_pkg::SUM_W-1:0] b_sum;
  logic signed [y2rgb_pkg::SUM_W-1:0] g_sum;
  logic signed [y2rgb_pkg::SUM_W-1:0] r_sum;

  always_comb begin
    luma_s = $signed({3'b000, luma});
    b_sum = luma_s + y2rgb_pkg::SUM_W'(term.cb);
    g_sum = luma_s - y2rgb_pkg::SUM_W'(term.cg);
    r_sum = luma_s + y2rgb_pkg::SUM_W'(term.cr);
    pix.b = sat8(b_sum);
    pix.g = sat8(g_sum);
    pix.r = sat8(r_sum);
  end

endmodule
`default_nettype wire

/* sv/y2rgb_merge.sv */
`default_nettype none
module y2rgb_merge (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire y2rgb_pkg::pixel_t first_pix,
  input  wire y2rgb_pkg::pixel_t second_pix,
  input  wire y2rgb_pkg::meta_t  meta,
  y2rgb_out_if.source            res
);

  y2rgb_pkg::pixel_t left_pix;
  y2rgb_pkg::pixel_t right_pix;

  // mirrored lines swap the two pixels of a pair
  always_comb begin
    if (meta.mirror) begin
      left_pix = second_pix;
      right_pix = first_pix;
    end else begin
      left_pix = first_pix;
      right_pix = second_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (take) begin
      res.blue_left <= left_pix.b;
      res.green_left <= left_pix.g;
      res.red_left <= left_pix.r;
      res.blue_right <= right_pix.b;
      res.green_right <= right_pix.g;
      res.red_right <= right_pix.r;
      res.pair_column <= meta.col;
      res.line_index <= meta.line;
      res.end_of_line <= meta.eol;
      res.end_of_frame <= meta.eof;
    end
  end

endmodule
`default_nettype wire

/* sv/yuyv_to_rgb24_mirror_unit.sv */
// channel    | dir | payload                                        | handshake
// -----------+-----+------------------------------------------------+------------
// pixel_in   | in  | y_first, u_chroma, y_second, v_chroma          | valid/ready
// pixel_out  | out | bgr left/right, pair_column, line_index, marks | valid/ready
// cfg        | in  | cfg_index, cfg_data                            | cfg_we only
//
// one request per clock sustained unless pixel_out stalls
// stage one holds the chroma products, the output register holds the merged pair
// pixel_in.ready drops only when both stages are full and pixel_out is stalled
// synchronous reset clears the counters and valids and loads the register defaults
`default_nettype none
`include "yuyv_to_rgb24_mirror_unit_assert.svh"
module yuyv_to_rgb24_mirror_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [y2rgb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [y2rgb_pkg::CFG_DATA_W-1:0]    cfg_data,
  y2rgb_in_if.sink                                 pixel_in,
  y2rgb_out_if.source                              pixel_out
);

  logic [y2rgb_pkg::LINE_PAIRS_W-1:0]  line_pairs;
  logic [y2rgb_pkg::FRAME_LINES_W-1:0] frame_lines;
  logic                                mirror_enable;
  logic [y2rgb_pkg::PAIR_W-1:0]        pair_cnt;
  logic [y2rgb_pkg::LINE_W-1:0]        line_cnt;

  logic [y2rgb_pkg::LINE_PAIRS_W-1:0]  lp;
  logic [y2rgb_pkg::FRAME_LINES_W-1:0] fl;
  logic [y2rgb_pkg::LINE_PAIRS_W-1:0]  pair_ext;
  logic                                eol_now;
  logic                                eof_now;
  logic [y2rgb_pkg::PAIR_W-1:0]        col_now;

  logic              in_acc;
  logic              out_adv;
  logic              s1_take;
  logic              s1_valid;
  y2rgb_pkg::prod_t  in_prod;
  y2rgb_pkg::prod_t  s1_prod;
  logic [7:0]        s1_y_first;
  logic [7:0]        s1_y_second;
  y2rgb_pkg::meta_t  s1_meta;
  y2rgb_pkg::term_t  s1_term;
  y2rgb_pkg::pixel_t first_pix;
  y2rgb_pkg::pixel_t second_pix;

  // out of range sizes clamp to 1..max
  always_comb begin
    priority if (line_pairs == '0) begin
      lp = y2rgb_pkg::LINE_PAIRS_W'(1);
    end else if (line_pairs > y2rgb_pkg::LINE_PAIRS_W'(y2rgb_pkg::MAX_LINE_PAIRS)) begin
      lp = y2rgb_pkg::LINE_PAIRS_W'(y2rgb_pkg::MAX_LINE_PAIRS);
    end else begin
      lp = line_pairs;
    end
    priority if (frame_lines == '0) begin
      fl = y2rgb_pkg::FRAME_LINES_W'(1);
    end else if (frame_lines > y2rgb_pkg::FRAME_LINES_W'(y2rgb_pkg::MAX_LINES)) begin
      fl = y2rgb_pkg::FRAME_LINES_W'(y2rgb_pkg::MAX_LINES);
    end else begin
      fl = frame_lines;
    end
  end

  always_comb begin
    pair_ext = {1'b0, pair_cnt};
    eol_now = (pair_ext + 11'd1) >= lp;
    eof_now = eol_now && (({1'b0, line_cnt} + 12'd1) >= fl);
    if (mirror_enable) begin
      if (pair_ext < lp) begin
        col_now = y2rgb_pkg::PAIR_W'(lp - 11'd1 - pair_ext);
      end else begin
        col_now = '0;
      end
    end else begin
      col_now = pair_cnt;
    end
  end

  assign out_adv = !pixel_out.valid || pixel_out.ready;
  assign s1_take = s1_valid && out_adv;
  assign pixel_in.ready = !s1_valid || out_adv;
  assign in_acc = pixel_in.valid && pixel_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pairs <= y2rgb_pkg::LINE_PAIRS_RESET;
      frame_lines <= y2rgb_pkg::FRAME_LINES_RESET;
      mirror_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        y2rgb_pkg::REG_LINE_PAIRS: line_pairs <= cfg_data[y2rgb_pkg::LINE_PAIRS_W-1:0];
        y2rgb_pkg::REG_FRAME_LINES: frame_lines <= cfg_data[y2rgb_pkg::FRAME_LINES_W-1:0];
        y2rgb_pkg::REG_MIRROR: mirror_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_cnt <= '0;
      line_cnt <= '0;
    end else if (in_acc) begin
      if (eol_now) begin
        pair_cnt <= '0;
        line_cnt <= eof_now ? '0 : line_cnt + 11'd1;
      end else begin
        pair_cnt <= pair_cnt + 10'd1;
      end
    end
  end

  y2rgb_chroma u_chroma (
    .u_chroma (pixel_in.u_chroma),
    .v_chroma (pixel_in.v_chroma),
    .prod     (in_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
    if (in_acc) begin
      s1_prod <= in_prod;
      s1_y_first <= pixel_in.y_first;
      s1_y_second <= pixel_in.y_second;
      s1_meta.col <= col_now;
      s1_meta.line <= line_cnt;
      s1_meta.eol <= eol_now;
      s1_meta.eof <= eof_now;
      s1_meta.mirror <= mirror_enable;
    end
  end

  // arithmetic shift right by 8
  always_comb begin
    s1_term.cb = s1_prod.blue[y2rgb_pkg::PROD_W-1:8];
    s1_term.cr = s1_prod.red[y2rgb_pkg::PROD_W-1:8];
    s1_term.cg = s1_prod.green[y2rgb_pkg::PROD_W-1:8];
  end

  y2rgb_lane u_lane_first (
    .luma (s1_y_first),
    .term (s1_term),
    .pix  (first_pix)
  );

  y2rgb_lane u_lane_second (
    .luma (s1_y_second),
    .term (s1_term),
    .pix  (second_pix)
  );

  y2rgb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .take       (s1_take),
    .first_pix  (first_pix),
    .second_pix (second_pix),
    .meta       (s1_meta),
    .res        (pixel_out)
  );

  `Y2RGB_ASSERT_NEXT(a_pair_wrap, in_acc && eol_now, pair_cnt == '0)
  `Y2RGB_ASSERT_NEXT(a_line_wrap, in_acc && eof_now, line_cnt == '0)
  `Y2RGB_ASSERT(a_eof_on_eol, s1_valid && s1_meta.eof |-> s1_meta.eol)
  `Y2RGB_ASSERT(a_full_stall, s1_valid && pixel_out.valid && !pixel_out.ready |-> !pixel_in.ready)

endmodule
`default_nettype wire

/* tb/sv/tb_yuyv_to_rgb24_mirror_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_yuyv_to_rgb24_mirror_unit;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_PAIRS = 900;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    logic [7:0]                   blue_left;
    logic [7:0]                   green_left;
    logic [7:0]                   red_left;
    logic [7:0]                   blue_right;
    logic [7:0]                   green_right;
    logic [7:0]                   red_right;
    logic [y2rgb_pkg::PAIR_W-1:0] pair_column;
    logic [y2rgb_pkg::LINE_W-1:0] line_index;
    logic                         end_of_line;
    logic                         end_of_frame;
  } pair_result_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [y2rgb_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [y2rgb_pkg::CFG_DATA_W-1:0]  reg_value;
    logic [7:0]                        y0;
    logic [7:0]                        u;
    logic [7:0]                        y1;
    logic [7:0]                        v;
    pair_result_t                      want;
  } stim_row_t;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [y2rgb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [y2rgb_pkg::CFG_DATA_W-1:0]  cfg_data;

  y2rgb_in_if  pix_in();
  y2rgb_out_if pix_out();

  yuyv_to_rgb24_mirror_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_in(pix_in),
    .pixel_out(pix_out)
  );

  // converter state as the block should hold it
  logic [y2rgb_pkg::LINE_PAIRS_W-1:0]  lp_reg;
  logic [y2rgb_pkg::FRAME_LINES_W-1:0] fl_reg;
  logic                                mirror_reg;
  logic [y2rgb_pkg::PAIR_W-1:0]        pair_cnt;
  logic [y2rgb_pkg::LINE_W-1:0]        line_cnt;

  pair_result_t expected_pairs[$];
  stim_row_t    dir_rows[$];

  int  errors;
  int  cycle_count;
  int  pairs_sent;
  int  results_checked;
  int  frames_closed;
  int  mirrored_pairs;
  int  reg_writes;
  bit  no_idle;
  bit  press_out;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] sat8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic convert_pair(input logic [7:0] y0, u, y1, v, output pair_result_t r);
    int  du, dv, cb, cr, cg, lp, fl, p, l, yl, yr, col;
    bit  eol, eof;
    du = int'(u) - 128;
    dv = int'(v) - 128;
    cb = (du * 454) >>> 8;
    cr = (dv * 359) >>> 8;
    cg = (du * 88 + dv * 183) >>> 8;
    lp = (lp_reg == 0) ? 1 : ((lp_reg > y2rgb_pkg::MAX_LINE_PAIRS) ?
         y2rgb_pkg::MAX_LINE_PAIRS : int'(lp_reg));
    fl = (fl_reg == 0) ? 1 : ((fl_reg > y2rgb_pkg::MAX_LINES) ?
         y2rgb_pkg::MAX_LINES : int'(fl_reg));
    p = int'(pair_cnt);
    l = int'(line_cnt);
    eol = (p + 1 >= lp);
    eof = eol && (l + 1 >= fl);
    yl = int'(y0);
    yr = int'(y1);
    col = p;
    if (mirror_reg) begin
      yl = int'(y1);
      yr = int'(y0);
      col = (p < lp) ? (lp - 1 - p) : 0;
      mirrored_pairs++;
    end
    r.blue_left = sat8(yl + cb);
    r.green_left = sat8(yl - cg);
    r.red_left = sat8(yl + cr);
    r.blue_right = sat8(yr + cb);
    r.green_right = sat8(yr - cg);
    r.red_right = sat8(yr + cr);
    r.pair_column = col[y2rgb_pkg::PAIR_W-1:0];
    r.line_index = l[y2rgb_pkg::LINE_W-1:0];
    r.end_of_line = eol;
    r.end_of_frame = eof;
    if (eol) begin
      pair_cnt = '0;
      line_cnt = eof ? '0 : line_cnt + 1'b1;
    end else begin
      pair_cnt = pair_cnt + 1'b1;
    end
    if (eof) frames_closed++;
  endtask

  function automatic pair_result_t make_pair(input logic [7:0] bl, gl, rl, br, gr, rr,
                                             input int col, line, input bit eol, eof);
    pair_result_t r;
    r.blue_left = bl;
    r.green_left = gl;
    r.red_left = rl;
    r.blue_right = br;
    r.green_right = gr;
    r.red_right = rr;
    r.pair_column = col[y2rgb_pkg::PAIR_W-1:0];
    r.line_index = line[y2rgb_pkg::LINE_W-1:0];
    r.end_of_line = eol;
    r.end_of_frame = eof;
    return r;
  endfunction

  function automatic stim_row_t item_row(input row_kind_t kind, input logic [7:0] y0, u, y1, v,
                                         input pair_result_t want);
    stim_row_t r;
    r = '0;
    r.kind = kind;
    r.y0 = y0;
    r.u = u;
    r.y1 = y1;
    r.v = v;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [y2rgb_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [y2rgb_pkg::CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  task automatic write_reg(input logic [y2rgb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [y2rgb_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      y2rgb_pkg::REG_LINE_PAIRS: lp_reg = val[y2rgb_pkg::LINE_PAIRS_W-1:0];
      y2rgb_pkg::REG_FRAME_LINES: fl_reg = val[y2rgb_pkg::FRAME_LINES_W-1:0];
      y2rgb_pkg::REG_MIRROR: mirror_reg = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // drive one request, hold it until accepted
  task automatic send_pair(input logic [7:0] y0, u, y1, v, input bit typed,
                           input pair_result_t want);
    int           gap;
    pair_result_t r;
    gap = no_idle ? 0 : (($urandom_range(0, 99) < 60) ? 0 : pick_wait());
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.y_first <= y0;
    pix_in.u_chroma <= u;
    pix_in.y_second <= y1;
    pix_in.v_chroma <= v;
    @(posedge clk);
    while (pix_in.ready !== 1'b1) @(posedge clk);
    convert_pair(y0, u, y1, v, r);
    expected_pairs.push_back(typed ? want : r);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [10:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    int stall;
    int hold;
    pair_result_t want;
    stall = 0;
    hold = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (press_out) begin
        press_out = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        pix_out.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pix_out.ready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        pix_out.ready <= 1'b1;
      end else begin
        stall = pick_wait() - 1;
        pix_out.ready <= 1'b0;
      end
      @(posedge clk);
      if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: result with nothing expected, column %0d line %0d", $time,
                   pix_out.pair_column, pix_out.line_index);
          errors++;
        end else begin
          want = expected_pairs.pop_front();
          check_field("blue_left", want.blue_left, pix_out.blue_left);
          check_field("green_left", want.green_left, pix_out.green_left);
          check_field("red_left", want.red_left, pix_out.red_left);
          check_field("blue_right", want.blue_right, pix_out.blue_right);
          check_field("green_right", want.green_right, pix_out.green_right);
          check_field("red_right", want.red_right, pix_out.red_right);
          check_field("pair_column", want.pair_column, pix_out.pair_column);
          check_field("line_index", want.line_index, pix_out.line_index);
          check_field("end_of_line", want.end_of_line, pix_out.end_of_line);
          check_field("end_of_frame", want.end_of_frame, pix_out.end_of_frame);
          results_checked++;
        end
      end
    end
  end

  initial begin
    int random_pairs;
    int phase;
    int n;
    int lp_val;
    int fl_val;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.y_first = '0;
    pix_in.u_chroma = '0;
    pix_in.y_second = '0;
    pix_in.v_chroma = '0;
    pix_out.ready = 1'b0;
    errors = 0;
    cycle_count = 0;
    pairs_sent = 0;
    results_checked = 0;
    frames_closed = 0;
    mirrored_pairs = 0;
    reg_writes = 0;
    no_idle = 1'b0;
    press_out = 1'b0;
    lp_reg = y2rgb_pkg::LINE_PAIRS_RESET;
    fl_reg = y2rgb_pkg::FRAME_LINES_RESET;
    mirror_reg = 1'b0;
    pair_cnt = '0;
    line_cnt = '0;

    // reset defaults, neutral and saturating chroma
    dir_rows.push_back(item_row(ROW_CHECKED, 8'd0, 8'd128, 8'd0, 8'd128,
                                make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(item_row(ROW_CHECKED, 8'd255, 8'd128, 8'd255, 8'd128,
                                make_pair(255, 255, 255, 255, 255, 255, 1, 0, 0, 0)));
    dir_rows.push_back(item_row(ROW_CHECKED, 8'd0, 8'd255, 8'd255, 8'd255,
                                make_pair(225, 0, 178, 255, 121, 255, 2, 0, 0, 0)));
    dir_rows.push_back(item_row(ROW_CHECKED, 8'd255, 8'd0, 8'd0, 8'd0,
                                make_pair(28, 255, 75, 0, 136, 0, 3, 0, 0, 0)));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd128, 8'd255, 8'd128, 8'd0, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd16, 8'd0, 8'd235, 8'd255, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd1, 8'd127, 8'd254, 8'd129, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd200, 8'd129, 8'd50, 8'd127, '0));
    // counter now past the new line end
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_LINE_PAIRS, 12'd2));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd90, 8'd60, 8'd170, 8'd200, '0));
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_MIRROR, 12'd1));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd10, 8'd100, 8'd240, 8'd30, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd240, 8'd30, 8'd10, 8'd100, '0));
    // zero registers act as one
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_LINE_PAIRS, 12'd0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd77, 8'd33, 8'd188, 8'd222, '0));
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_FRAME_LINES, 12'd0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd55, 8'd200, 8'd66, 8'd20, '0));
    // oversized registers clamp to the maximum
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_LINE_PAIRS, 12'd4095));
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_FRAME_LINES, 12'd4095));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd255, 8'd255, 8'd0, 8'd0, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd0, 8'd0, 8'd255, 8'd255, '0));
    // mirrored pair past the line end
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_LINE_PAIRS, 12'd1));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd123, 8'd45, 8'd67, 8'd89, '0));
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_LINE_PAIRS, 12'd2));
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_FRAME_LINES, 12'd2));
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_MIRROR, 12'd0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd1, 8'd2, 8'd3, 8'd4, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd5, 8'd6, 8'd7, 8'd8, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd9, 8'd10, 8'd11, 8'd12, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd13, 8'd14, 8'd15, 8'd16, '0));
    dir_rows.push_back(reg_row(y2rgb_pkg::REG_MIRROR, 12'd1));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd250, 8'd240, 8'd230, 8'd220, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd210, 8'd200, 8'd190, 8'd180, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd170, 8'd160, 8'd150, 8'd140, '0));
    dir_rows.push_back(item_row(ROW_ITEM, 8'd130, 8'd120, 8'd110, 8'd100, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
      end else begin
        send_pair(dir_rows[i].y0, dir_rows[i].u, dir_rows[i].y1, dir_rows[i].v,
                  dir_rows[i].kind == ROW_CHECKED, dir_rows[i].want);
      end
    end

    random_pairs = 0;
    phase = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: lp_val = 0;
        1: lp_val = y2rgb_pkg::MAX_LINE_PAIRS;
        2: lp_val = $urandom_range(y2rgb_pkg::MAX_LINE_PAIRS + 1, 4095);
        default: lp_val = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: fl_val = 0;
        1: fl_val = y2rgb_pkg::MAX_LINES;
        2: fl_val = $urandom_range(y2rgb_pkg::MAX_LINES + 1, 4095);
        default: fl_val = $urandom_range(1, 5);
      endcase
      if ($urandom_range(0, 2) != 0) begin
        write_reg(y2rgb_pkg::REG_LINE_PAIRS, lp_val[y2rgb_pkg::CFG_DATA_W-1:0]);
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(y2rgb_pkg::REG_FRAME_LINES, fl_val[y2rgb_pkg::CFG_DATA_W-1:0]);
      end
      if ($urandom_range(0, 1) != 0) begin
        write_reg(y2rgb_pkg::REG_MIRROR, y2rgb_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      end
      no_idle = ($urandom_range(0, 5) == 0);
      n = $urandom_range(20, 70);
      if (phase == 3) begin
        no_idle = 1'b1;
        press_out = 1'b1;
        n = 40;
      end
      for (int k = 0; k < n; k++) begin
        if (!no_idle && $urandom_range(0, 99) == 0) wait_idle();
        send_pair(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1'b0, '0);
        random_pairs++;
      end
      phase++;
    end

    wait_idle();
    no_idle = 1'b0;
    repeat (10) @(negedge clk);
    $display("run: %0d pairs over %0d setting phases and %0d register writes",
             pairs_sent, phase, reg_writes);
    $display("run: %0d results checked, %0d mirrored, %0d frames closed",
             results_checked, mirrored_pairs, frames_closed);
    if (errors == 0 && expected_pairs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
